// File: hw/rtl/vtpr_pkg.sv
// Shared types, constants and elaboration-time helpers for the virtual texture
// page request block. Depends on nothing; every other file but vtpr_ram imports it.
`timescale 1ns / 1ps

package vtpr_pkg;

  // Default geometry, handed to the top-level parameters.
  localparam int unsigned BASE_TILES_DEF    = 1024;
  localparam int unsigned LEVELS_DEF        = 11;
  localparam int unsigned PAGES_PER_ROW_DEF = 32;
  localparam int unsigned CACHE_PAGES_DEF   = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF   = 2;

  // Fixed field widths.
  localparam int WORD_W   = 64;
  localparam int LEVEL_W  = 4;
  localparam int COORD_W  = 8;
  localparam int ENTRY_W  = 20;
  localparam int PNUM_W   = 10;
  localparam int SRC_W    = 28;
  localparam int EPOCH_W  = 8;

  // Source address layout: level from bit 24 up, rows 4096 apart.
  localparam int SRC_LEVEL_SHIFT = 24;
  localparam int SRC_ROW_SHIFT   = 12;

  typedef enum logic [1:0] {
    CMD_FEEDBACK = 2'd0,
    CMD_FRAME    = 2'd1,
    CMD_READ     = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_READ = 2'd1,
    KIND_FULL = 2'd2
  } kind_t;

  typedef struct packed {
    cmd_t              command;
    logic [WORD_W-1:0] feedback_word;
  } in_item_t;

  typedef struct packed {
    kind_t              result_kind;
    logic [ENTRY_W-1:0] page_entry;
    logic               entry_empty;
    logic [PNUM_W-1:0]  page_number;
    logic [SRC_W-1:0]   source_address;
  } out_item_t;

  // Number of table entries: one per tile of every level, plus one spare.
  function automatic longint unsigned table_depth(int unsigned base_tiles);
    longint unsigned b;
    b = longint'(base_tiles);
    return b * b * 4 / 3 + 1;
  endfunction

  // First table slot of a level: the tile counts of all lower-indexed (finer) levels.
  function automatic longint unsigned level_base(int unsigned base_tiles, int unsigned lvl);
    longint unsigned acc;
    longint unsigned s;
    acc = 0;
    for (int unsigned k = 0; k < lvl; k++) begin
      s   = longint'(base_tiles) >> k;
      acc = acc + s * s;
    end
    return acc;
  endfunction

endpackage

// File: hw/rtl/vtpr_ram.sv
// Generic simple dual-port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module vtpr_ram #(
  parameter int              WIDTH = 8,
  parameter longint unsigned DEPTH = 2,
  localparam int             AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/vtpr_front.sv
// Front end: decodes a command and feedback word, range-checks the tile and
// computes its table slot and source address. Depends on vtpr_pkg.
`timescale 1ns / 1ps

module vtpr_front #(
  parameter int unsigned     BASE_TILES  = vtpr_pkg::BASE_TILES_DEF,
  parameter int unsigned     LEVELS      = vtpr_pkg::LEVELS_DEF,
  localparam longint unsigned TABLE_DEPTH = vtpr_pkg::table_depth(BASE_TILES),
  localparam int             SLOT_W      = $clog2(TABLE_DEPTH),
  localparam int             ITEM_W      = 2 + SLOT_W + vtpr_pkg::LEVEL_W + vtpr_pkg::SRC_W
) (
  input  vtpr_pkg::in_item_t in_data,
  output logic               keep,
  output logic [ITEM_W-1:0]  item
);

  import vtpr_pkg::*;

  localparam int TILE_W = $clog2(BASE_TILES + 1);

  typedef struct packed {
    cmd_t               op;
    logic [SLOT_W-1:0]  slot;
    logic [LEVEL_W-1:0] level;
    logic [SRC_W-1:0]   src;
  } item_t;

  logic [SLOT_W-1:0]   lvl_base [2**LEVEL_W];
  logic [15:0]         lvl16;
  logic [15:0]         x16;
  logic [15:0]         y16;
  logic [LEVEL_W-1:0]  lvl;
  logic [TILE_W-1:0]   size_v;
  logic [TILE_W-1:0]   x_t;
  logic [TILE_W-1:0]   y_t;
  logic [2*TILE_W-1:0] row_off;
  logic                is_empty;
  logic                in_range;
  item_t               item_s;

  for (genvar g = 0; g < 2**LEVEL_W; g++) begin : g_base
    assign lvl_base[g] = SLOT_W'(level_base(BASE_TILES, g));
  end

  assign lvl16    = in_data.feedback_word[63:48];
  assign x16      = in_data.feedback_word[47:32];
  assign y16      = in_data.feedback_word[31:16];
  assign lvl      = lvl16[LEVEL_W-1:0];
  assign size_v   = TILE_W'(BASE_TILES) >> lvl;
  assign x_t      = x16[TILE_W-1:0];
  assign y_t      = y16[TILE_W-1:0];
  assign row_off  = y_t * size_v;
  assign is_empty = (in_data.feedback_word == '1);
  assign in_range = (lvl16 < 16'(LEVELS)) && (x16 < 16'(size_v)) && (y16 < 16'(size_v));

  always_comb begin
    item_s.op    = in_data.command;
    item_s.slot  = lvl_base[lvl] + SLOT_W'(x_t) + SLOT_W'(row_off);
    item_s.level = lvl;
    item_s.src   = (SRC_W'(lvl) << SRC_LEVEL_SHIFT)
                 | (SRC_W'(x16) + (SRC_W'(y16) << SRC_ROW_SHIFT));
    case (in_data.command)
      CMD_FRAME:              keep = 1'b1;
      CMD_FEEDBACK, CMD_READ: keep = !is_empty && in_range;
      default:                keep = 1'b0;
    endcase
  end

  assign item = item_s;

endmodule

// File: hw/rtl/vtpr_queue.sv
// Short FIFO of decoded requests between the front and back ends.
// Depends on vtpr_pkg for its default depth.
`timescale 1ns / 1ps

module vtpr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = vtpr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty,
  output logic             full
);

  import vtpr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/vtpr_back.sv
// Back end: owns the indirection table RAM, the frame epoch and the page
// allocator, and produces the results. Depends on vtpr_pkg and vtpr_ram.
`timescale 1ns / 1ps

module vtpr_back #(
  parameter int unsigned     BASE_TILES    = vtpr_pkg::BASE_TILES_DEF,
  parameter int unsigned     PAGES_PER_ROW = vtpr_pkg::PAGES_PER_ROW_DEF,
  parameter int unsigned     CACHE_PAGES   = vtpr_pkg::CACHE_PAGES_DEF,
  localparam longint unsigned TABLE_DEPTH  = vtpr_pkg::table_depth(BASE_TILES),
  localparam int             SLOT_W        = $clog2(TABLE_DEPTH),
  localparam int             ITEM_W        = 2 + SLOT_W + vtpr_pkg::LEVEL_W + vtpr_pkg::SRC_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  logic [ITEM_W-1:0]   q_head,
  output logic                q_pop,
  output logic                clearing,
  output logic                out_valid,
  output vtpr_pkg::out_item_t out_data
);

  import vtpr_pkg::*;

  localparam int PAGE_W  = (CACHE_PAGES > 1) ? $clog2(CACHE_PAGES) : 1;
  localparam int NP_W    = $clog2(CACHE_PAGES + 1);
  localparam int TBL_W   = EPOCH_W + PAGE_W + 2 * COORD_W;

  typedef struct packed {
    cmd_t               op;
    logic [SLOT_W-1:0]  slot;
    logic [LEVEL_W-1:0] level;
    logic [SRC_W-1:0]   src;
  } item_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [PAGE_W-1:0]  page;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } tbl_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  item_t              cur_r, cur_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [NP_W-1:0]    next_page_r, next_page_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [SLOT_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  item_t              head;
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  tbl_entry_t         ram_wdata;
  logic               ram_re;
  logic [SLOT_W-1:0]  ram_raddr;
  logic [TBL_W-1:0]   ram_rdata;
  tbl_entry_t         rd_entry;
  logic               hit;

  assign head     = item_t'(q_head);
  assign rd_entry = tbl_entry_t'(ram_rdata);
  assign hit      = (rd_entry.tag == epoch_r);
  assign clearing = (state_r == ST_CLEAR);

  vtpr_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    epoch_nxt     = epoch_r;
    next_page_nxt = next_page_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r.slot;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = head.slot;
    q_pop         = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        // Tag zero never matches a live epoch, so this empties the entry.
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        if (clr_cnt_r == SLOT_W'(TABLE_DEPTH - 1)) begin
          state_nxt   = ST_IDLE;
          clr_cnt_nxt = '0;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (head.op == CMD_FRAME) begin
            next_page_nxt = '0;
            col_nxt       = '0;
            row_nxt       = '0;
            if (epoch_r == '1) begin
              epoch_nxt = EPOCH_W'(1);
              state_nxt = ST_CLEAR;
            end else begin
              epoch_nxt = epoch_r + 1'b1;
            end
          end else begin
            ram_re    = 1'b1;
            cur_nxt   = head;
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        state_nxt = ST_IDLE;
        if (cur_r.op == CMD_READ) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.result_kind    = KIND_READ;
          out_data_nxt.page_entry     = hit ? {cur_r.level, rd_entry.col, rd_entry.row} : '0;
          out_data_nxt.entry_empty    = !hit;
          out_data_nxt.page_number    = hit ? PNUM_W'(rd_entry.page) : '0;
          out_data_nxt.source_address = '0;
        end else if (!hit) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.source_address = cur_r.src;
          out_data_nxt.entry_empty    = 1'b0;
          if (next_page_r == NP_W'(CACHE_PAGES)) begin
            out_data_nxt.result_kind = KIND_FULL;
            out_data_nxt.page_entry  = '0;
            out_data_nxt.page_number = '0;
          end else begin
            ram_we                   = 1'b1;
            ram_wdata.tag            = epoch_r;
            ram_wdata.page           = next_page_r[PAGE_W-1:0];
            ram_wdata.col            = col_r;
            ram_wdata.row            = row_r;
            out_data_nxt.result_kind = KIND_LOAD;
            out_data_nxt.page_entry  = {cur_r.level, col_r, row_r};
            out_data_nxt.page_number = PNUM_W'(next_page_r);
            next_page_nxt            = next_page_r + 1'b1;
            if (col_r == COORD_W'(PAGES_PER_ROW - 1)) begin
              col_nxt = '0;
              row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      epoch_r     <= EPOCH_W'(1);
      next_page_r <= '0;
      col_r       <= '0;
      row_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      next_page_r <= next_page_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_LOOK))
    else $error("result strobe without a preceding table lookup");

  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("frame epoch reached the cleared tag value");

  a_page_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_page_r <= NP_W'(CACHE_PAGES))
    else $error("page allocator ran past the cache size");

  a_map_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == ST_LOOK) |-> (ram_wdata.tag == epoch_r && !hit &&
                                        cur_r.op == CMD_FEEDBACK))
    else $error("table mapped a tile that was already live or not a feedback request");

endmodule

// File: hw/rtl/virtual_texture_page_request.sv
// Top level of the virtual texture page request block: front-end decoder,
// request queue and table back end. Depends on vtpr_pkg and all vtpr_* modules.
`timescale 1ns / 1ps

//  Channel  Ports                   Direction  Handshake
//  ------------------------------------------------------------------------------
//  input    start, busy, in_data    in         taken when start is high, busy low
//  result   out_valid, out_data     out        one-cycle strobe, cannot be held off
//
// A request is decoded in the cycle that it is taken and enters the two-deep queue at that
// edge. A feedback or read request then passes through the back end's idle and lookup
// states (table RAM read, then tag check, mapping write and result register), and the back
// end pops no new request until that lookup is done; its result strobe is registered. A
// new-frame request is handled in the idle state alone. After reset, and whenever the frame
// epoch wraps, the table (BASE_TILES*BASE_TILES*4/3+1 entries, 1398102 with the default
// geometry) is swept one entry per cycle with busy high; busy also rises when the queue
// is full. The result side never stalls.

module virtual_texture_page_request #(
  parameter int unsigned BASE_TILES    = vtpr_pkg::BASE_TILES_DEF,
  parameter int unsigned LEVELS        = vtpr_pkg::LEVELS_DEF,
  parameter int unsigned PAGES_PER_ROW = vtpr_pkg::PAGES_PER_ROW_DEF,
  parameter int unsigned CACHE_PAGES   = vtpr_pkg::CACHE_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  vtpr_pkg::in_item_t  in_data,
  output logic                out_valid,
  output vtpr_pkg::out_item_t out_data
);

  import vtpr_pkg::*;

  // Table size and slot width follow from the finest level's tile count.
  localparam longint unsigned TABLE_DEPTH = table_depth(BASE_TILES);
  localparam int              SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int              ITEM_W      = 2 + SLOT_W + LEVEL_W + SRC_W;

  logic              keep;
  logic [ITEM_W-1:0] front_item;
  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  logic              q_full;
  logic [ITEM_W-1:0] q_head;
  logic              clearing;

  // The decoder drops requests that can never produce anything: the empty word,
  // an out-of-range tile and the unused command. Those are still taken.
  vtpr_front #(
    .BASE_TILES (BASE_TILES),
    .LEVELS     (LEVELS)
  ) u_front (
    .in_data (in_data),
    .keep    (keep),
    .item    (front_item)
  );

  // Requests are refused while the table is being swept, so that nothing new
  // waits behind the sweep, and while the queue is full.
  assign busy   = q_full || clearing;
  assign q_push = start && !busy && keep;

  vtpr_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_item),
    .pop       (q_pop),
    .head_data (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // The back end keeps mappings tagged with a frame epoch; a new frame advances
  // the epoch, which empties every entry at once, and sweeps the table when it wraps.
  vtpr_back #(
    .BASE_TILES    (BASE_TILES),
    .PAGES_PER_ROW (PAGES_PER_ROW),
    .CACHE_PAGES   (CACHE_PAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
